// ===== rtl/hnc_pkg.sv =====
// Shared types, constants and helper functions for the HEVC NAL unit classifier.
// Used by every module under rtl; depends on nothing else.
package hnc_pkg;

  // Configuration port geometry: one 32-bit register per word.
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam int DATA_W    = 32;
  localparam logic [REG_IDX_W-1:0] REG_FRAMING_MODE = '0;

  // Queue sizes.
  localparam int FRONT_PTR_W = 2;
  localparam int FRONT_DEPTH = 1 << FRONT_PTR_W;
  localparam int OUT_PTR_W   = 1;
  localparam int OUT_DEPTH   = 1 << OUT_PTR_W;

  // Held header candidate and the bytes that follow it.
  localparam int HELD_DEPTH = 4;
  localparam logic [2:0] HELD_FULL = 3'd4;
  localparam logic [2:0] HELD_MAX  = 3'd3;

  // Length-prefix walk: phases 0..3 collect the prefix.
  localparam logic [2:0] LP_HEADER = 3'd4;
  localparam logic [2:0] LP_BODY   = 3'd5;

  // NAL unit types of interest (bits 6..1 of the first NAL byte).
  localparam logic [5:0] NAL_IDR_W_RADL = 6'd19;
  localparam logic [5:0] NAL_IDR_N_LP   = 6'd20;
  localparam logic [5:0] NAL_VPS        = 6'd32;
  localparam logic [5:0] NAL_SPS        = 6'd33;
  localparam logic [5:0] NAL_PPS        = 6'd34;

  typedef enum logic {
    MODE_START_CODE = 1'b0,
    MODE_LENGTH     = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    VERDICT_WAIT  = 2'd0,
    VERDICT_COUNT = 2'd1,
    VERDICT_STOP  = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } item_t;

  typedef struct packed {
    logic scan_ok;
    logic keyframe_seen;
    logic param_sets_seen;
  } result_t;

  // One byte after the front end has tagged and pre-decoded it.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
    mode_t      mode;
    logic       is_zero;
    logic       is_one;
    logic       hdr_key;
    logic       hdr_pset;
  } work_t;

  typedef struct packed {
    logic found;
    logic key;
    logic pset;
  } flags_t;

  typedef logic [HELD_DEPTH-1:0][7:0] held_t;

  function automatic logic nal_is_key(logic [7:0] hdr);
    logic [5:0] t;
    t = hdr[6:1];
    return (t == NAL_IDR_W_RADL) || (t == NAL_IDR_N_LP);
  endfunction

  function automatic logic nal_is_pset(logic [7:0] hdr);
    logic [5:0] t;
    t = hdr[6:1];
    return (t == NAL_VPS) || (t == NAL_SPS) || (t == NAL_PPS);
  endfunction

  // Record one counted NAL whose header byte is given.
  function automatic flags_t add_nal(flags_t f, logic [7:0] hdr);
    flags_t r;
    r       = f;
    r.found = 1'b1;
    if (nal_is_key(hdr)) r.key = 1'b1;
    if (nal_is_pset(hdr)) r.pset = 1'b1;
    return r;
  endfunction

  // Decide whether a held candidate is a real header, an empty NAL, or unknown yet.
  function automatic verdict_t held_verdict(held_t hb, logic [2:0] n);
    verdict_t v;
    if (hb[0] != 8'd0) v = VERDICT_COUNT;
    else if (n >= 3'd2 && hb[1] != 8'd0) v = VERDICT_COUNT;
    else if (n >= 3'd3 && hb[2] > 8'd1) v = VERDICT_COUNT;
    else if (n >= HELD_FULL)
      v = (hb[2] == 8'd1 || hb[3] == 8'd1) ? VERDICT_STOP : VERDICT_COUNT;
    else v = VERDICT_WAIT;
    return v;
  endfunction

endpackage

// ===== rtl/hnc_front.sv =====
// Front end: accepts input words, tags them with the framing mode and pre-decodes them,
// then queues them for the scanner. Depends on hnc_pkg.
module hnc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  hnc_pkg::item_t  item,
  input  hnc_pkg::mode_t  framing_mode,
  output logic            work_valid,
  output hnc_pkg::work_t  work,
  input  logic            take
);

  hnc_pkg::work_t                 entries [hnc_pkg::FRONT_DEPTH];
  logic [hnc_pkg::FRONT_PTR_W-1:0] wr_ptr;
  logic [hnc_pkg::FRONT_PTR_W-1:0] rd_ptr;
  logic [hnc_pkg::FRONT_PTR_W:0]   count;
  hnc_pkg::work_t                 decoded;
  logic                           do_push;
  logic                           do_pop;

  always_comb begin
    decoded.data_byte     = item.data_byte;
    decoded.end_of_buffer = item.end_of_buffer;
    decoded.mode          = framing_mode;
    decoded.is_zero       = (item.data_byte == 8'd0);
    decoded.is_one        = (item.data_byte == 8'd1);
    decoded.hdr_key       = hnc_pkg::nal_is_key(item.data_byte);
    decoded.hdr_pset      = hnc_pkg::nal_is_pset(item.data_byte);
  end

  assign full       = (count == (hnc_pkg::FRONT_PTR_W + 1)'(hnc_pkg::FRONT_DEPTH));
  assign work_valid = (count != '0);
  assign work       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = take && work_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= decoded;
  end

endmodule

// ===== rtl/hnc_scan.sv =====
// Back end: start-code and length-prefix framing on one byte per cycle, but a final
// byte waits for result queue room; forms per-buffer verdict. Depends on hnc_pkg.
module hnc_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             work_valid,
  input  hnc_pkg::work_t   work,
  output logic             take,
  input  logic             res_full,
  output logic             res_push,
  output hnc_pkg::result_t res
);

  logic [1:0]          zero_run, zero_run_next;
  logic                header_armed, header_armed_next;
  hnc_pkg::held_t      held_bytes, held_bytes_next;
  logic [2:0]          held_count, held_count_next;
  logic                scan_stopped, scan_stopped_next;
  logic [2:0]          length_phase, length_phase_next;
  logic [31:0]         bytes_remaining, bytes_remaining_next;
  logic                length_error, length_error_next;
  hnc_pkg::flags_t     result_flags, result_flags_next;
  hnc_pkg::verdict_t   verdict;
  logic                stop_now;
  logic [31:0]         prefix;

  // A final byte needs room for its result; other bytes always go through.
  assign take     = work_valid && (!work.end_of_buffer || !res_full);
  assign res_push = take && work.end_of_buffer;

  always_comb begin
    zero_run_next        = zero_run;
    header_armed_next    = header_armed;
    held_bytes_next      = held_bytes;
    held_count_next      = held_count;
    scan_stopped_next    = scan_stopped;
    length_phase_next    = length_phase;
    bytes_remaining_next = bytes_remaining;
    length_error_next    = length_error;
    result_flags_next    = result_flags;
    verdict              = hnc_pkg::VERDICT_WAIT;
    stop_now             = 1'b0;
    prefix               = {bytes_remaining[23:0], work.data_byte};

    if (work.mode == hnc_pkg::MODE_START_CODE) begin
      if (!scan_stopped) begin
        // Extend a pending candidate with this byte and try to settle it.
        if (held_count != 3'd0) begin
          if (held_count < hnc_pkg::HELD_FULL) begin
            held_bytes_next[held_count[1:0]] = work.data_byte;
          end
          held_count_next = held_count + 3'd1;
          verdict = hnc_pkg::held_verdict(held_bytes_next, held_count_next);
          case (verdict)
            hnc_pkg::VERDICT_STOP: begin
              scan_stopped_next = 1'b1;
              held_count_next   = 3'd0;
              stop_now          = 1'b1;
            end
            hnc_pkg::VERDICT_COUNT: begin
              result_flags_next = hnc_pkg::add_nal(result_flags_next, held_bytes_next[0]);
              held_count_next   = 3'd0;
            end
            default: begin
            end
          endcase
        end
        if (!stop_now) begin
          // The byte after a start code is a new candidate; non-zero counts at once.
          if (header_armed) begin
            header_armed_next  = 1'b0;
            held_bytes_next[0] = work.data_byte;
            held_count_next    = 3'd1;
            if (!work.is_zero) begin
              result_flags_next.found = 1'b1;
              if (work.hdr_key) result_flags_next.key = 1'b1;
              if (work.hdr_pset) result_flags_next.pset = 1'b1;
              held_count_next = 3'd0;
            end
          end
          if (work.is_zero) begin
            if (zero_run < 2'd2) zero_run_next = zero_run + 2'd1;
          end else begin
            if (work.is_one && zero_run == 2'd2) header_armed_next = 1'b1;
            zero_run_next = 2'd0;
          end
          if (work.end_of_buffer && held_count_next != 3'd0) begin
            result_flags_next = hnc_pkg::add_nal(result_flags_next, held_bytes_next[0]);
            held_count_next   = 3'd0;
          end
        end
      end
    end else begin
      if (!length_error) begin
        if (length_phase < hnc_pkg::LP_HEADER) begin
          bytes_remaining_next = prefix;
          length_phase_next    = length_phase + 3'd1;
          if (length_phase == 3'd3 && prefix == 32'd0) length_error_next = 1'b1;
        end else if (length_phase == hnc_pkg::LP_HEADER || length_phase == hnc_pkg::LP_BODY) begin
          if (length_phase == hnc_pkg::LP_HEADER) begin
            held_bytes_next[0] = work.data_byte;
            held_count_next    = 3'd1;
            length_phase_next  = hnc_pkg::LP_BODY;
          end
          bytes_remaining_next = bytes_remaining - 32'd1;
          if (bytes_remaining == 32'd1) begin
            result_flags_next = hnc_pkg::add_nal(result_flags_next, held_bytes_next[0]);
            held_count_next   = 3'd0;
            length_phase_next = 3'd0;
          end
        end else begin
          length_phase_next = 3'd0;
        end
        // The buffer ending inside a NAL is a truncation error.
        if (work.end_of_buffer && !length_error_next && length_phase_next >= hnc_pkg::LP_HEADER) begin
          length_error_next = 1'b1;
        end
      end
    end

    res.scan_ok         = result_flags_next.found && !length_error_next;
    res.keyframe_seen   = result_flags_next.key;
    res.param_sets_seen = result_flags_next.pset;

    if (work.end_of_buffer) begin
      zero_run_next        = 2'd0;
      header_armed_next    = 1'b0;
      held_bytes_next      = '0;
      held_count_next      = 3'd0;
      scan_stopped_next    = 1'b0;
      length_phase_next    = 3'd0;
      bytes_remaining_next = 32'd0;
      length_error_next    = 1'b0;
      result_flags_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run        <= 2'd0;
      header_armed    <= 1'b0;
      held_bytes      <= '0;
      held_count      <= 3'd0;
      scan_stopped    <= 1'b0;
      length_phase    <= 3'd0;
      bytes_remaining <= 32'd0;
      length_error    <= 1'b0;
      result_flags    <= '0;
    end else if (take) begin
      zero_run        <= zero_run_next;
      header_armed    <= header_armed_next;
      held_bytes      <= held_bytes_next;
      held_count      <= held_count_next;
      scan_stopped    <= scan_stopped_next;
      length_phase    <= length_phase_next;
      bytes_remaining <= bytes_remaining_next;
      length_error    <= length_error_next;
      result_flags    <= result_flags_next;
    end
  end

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= hnc_pkg::HELD_MAX)
    else $error("held candidate count out of range");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    length_phase <= hnc_pkg::LP_BODY)
    else $error("length phase out of range");

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    (length_phase >= hnc_pkg::LP_HEADER && !length_error) |-> bytes_remaining != 32'd0)
    else $error("inside a NAL body with no bytes due");

  a_clear_after_buffer: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (result_flags == '0 && held_count == 3'd0 && !length_error))
    else $error("buffer state not cleared after final byte");
`endif

endmodule

// ===== rtl/hnc_out.sv =====
// Result queue: holds finished buffer verdicts until the consumer pops them.
// Depends on hnc_pkg.
module hnc_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_push,
  input  hnc_pkg::result_t res,
  output logic             res_full,
  output logic             empty,
  input  logic             pop,
  output hnc_pkg::result_t result
);

  hnc_pkg::result_t                entries [hnc_pkg::OUT_DEPTH];
  logic [hnc_pkg::OUT_PTR_W-1:0]   wr_ptr;
  logic [hnc_pkg::OUT_PTR_W-1:0]   rd_ptr;
  logic [hnc_pkg::OUT_PTR_W:0]     count;
  logic                            do_pop;

  assign res_full = (count == (hnc_pkg::OUT_PTR_W + 1)'(hnc_pkg::OUT_DEPTH));
  assign empty    = (count == '0);
  assign result   = entries[rd_ptr];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (res_push && !do_pop) count <= count + 1'b1;
      else if (!res_push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) entries[wr_ptr] <= res;
  end

endmodule

// ===== rtl/hevc_nal_unit_classifier.sv =====
// Top level of the HEVC NAL unit classifier: configuration register, front end,
// scanner and result queue. Depends on hnc_pkg, hnc_front, hnc_scan and hnc_out.
//
//   Channel   Handshake        Payload                                   Direction
//   input     push / full      item: data_byte[7:0], end_of_buffer      in
//   result    pop / empty      result: scan_ok, keyframe_seen,
//                              param_sets_seen                           out
//   config    APB psel/penable paddr, pwdata, prdata; framing_mode at 0 in/out
//
// The block takes one byte per cycle unless a final byte waits for result queue room;
// the scanner computes each byte's next framing state combinationally and registers
// it when it takes the byte. A final byte is written into the input queue; the
// scanner takes it from there and writes the verdict into the result queue at the
// same edge at which it takes the byte; the result queue then shows it on its ports.
// Reset is synchronous: it empties both queues, clears all scanning state and
// selects start-code framing. A full result queue holds back the final byte of a
// buffer and the bytes behind it, not earlier ones; a full input queue raises full.
module hevc_nal_unit_classifier (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  hnc_pkg::item_t              item,
  output logic                        empty,
  input  logic                        pop,
  output hnc_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hnc_pkg::ADDR_W-1:0]  paddr,
  input  logic [hnc_pkg::DATA_W-1:0]  pwdata,
  output logic [hnc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  hnc_pkg::mode_t   framing_mode;
  logic             work_valid;
  hnc_pkg::work_t   work;
  logic             take;
  logic             res_full;
  logic             res_push;
  hnc_pkg::result_t res;
  logic             reg_hit;

  // Registers sit one per 32-bit word; the byte offset bits are ignored.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[hnc_pkg::ADDR_W-1:2] == hnc_pkg::REG_FRAMING_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      framing_mode <= hnc_pkg::MODE_START_CODE;
    end else if (psel && penable && pwrite && reg_hit) begin
      framing_mode <= hnc_pkg::mode_t'(pwdata[0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) prdata[0] = framing_mode;
  end

  // Each byte carries the framing mode in force when it was accepted.
  hnc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .item         (item),
    .framing_mode (framing_mode),
    .work_valid   (work_valid),
    .work         (work),
    .take         (take)
  );

  hnc_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .work_valid (work_valid),
    .work       (work),
    .take       (take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  hnc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
